>>> hdl/sise_pkg.sv
// Shared types and codes for the sorted integer set engine.
package sise_pkg;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_MARK   = 3'd2;
  localparam logic [2:0] MODE_FINISH = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic                    mark;
    logic signed [VAL_W-1:0] val;
  } cell_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_INS_SHIFT,
    ST_REM_SHIFT,
    ST_COMPACT,
    ST_EDGE_LO,
    ST_EDGE_HI,
    ST_EDGE_END,
    ST_DONE
  } state_t;

endpackage

>>> hdl/sise_cmp.sv
// Shared signed compare unit: stored entry against the operand.
module sise_cmp (
  input  logic signed [sise_pkg::VAL_W-1:0] a,
  input  logic signed [sise_pkg::VAL_W-1:0] b,
  output sise_pkg::cmp_res_t                res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

>>> hdl/sise_ram.sv
// Entry store: one write port, one read port with registered read data.
module sise_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  sise_pkg::cell_t     wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output sise_pkg::cell_t     rdata
);

  sise_pkg::cell_t mem [DEPTH];
  sise_pkg::cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sorted_integer_set_engine.sv
// Sorted integer set engine: sequencer over the entry store and compare unit.
// Scan reads the entries in order until one is not less than the operand or the end is reached,
// then a decide state; insert shifts the entries from the position upward, remove shifts the
// entries above it down, finish compacts the marked entries with no scan, then EDGE_LO, EDGE_HI
// and EDGE_END read the least and greatest entries of a non-empty set into the result beat.
// Throughput: one item at a time; hold in DONE while out_ready is low. Sync reset empties.
module sorted_integer_set_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_mode,
  input  logic signed [sise_pkg::VAL_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic                                 out_status,
  output logic [sise_pkg::COUNT_W-1:0]         out_count,
  output logic signed [sise_pkg::VAL_W-1:0]    out_smallest,
  output logic signed [sise_pkg::VAL_W-1:0]    out_largest,
  output logic                                 out_is_empty
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sise_pkg::state_t state_r, state_nxt;

  logic [2:0]                        mode_r, mode_nxt;
  logic signed [sise_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     pos_r, pos_nxt;
  logic [CW-1:0]                     idx_r, idx_nxt;
  logic [CW-1:0]                     rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]                     wr_idx_r, wr_idx_nxt;
  logic                              pend_r, pend_nxt;
  logic                              found_r, found_nxt;
  logic                              status_r, status_nxt;
  logic signed [sise_pkg::VAL_W-1:0] lo_r, lo_nxt;
  logic signed [sise_pkg::VAL_W-1:0] hi_r, hi_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_found_r, out_found_nxt;
  logic                              out_status_r, out_status_nxt;
  logic [sise_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;
  logic signed [sise_pkg::VAL_W-1:0] out_smallest_r, out_smallest_nxt;
  logic signed [sise_pkg::VAL_W-1:0] out_largest_r, out_largest_nxt;
  logic                              out_is_empty_r, out_is_empty_nxt;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  sise_pkg::cell_t                   mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  sise_pkg::cell_t                   mem_rdata;
  sise_pkg::cmp_res_t                cmp_res;

  logic [CW-1:0] idx_dec, idx_inc, rd_up, rd_dn, pos_inc, wr_inc, count_inc, count_dec;
  logic          scan_hit, scan_end, ins_more, rem_more, full, out_free, keep_hit;

  sise_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sise_cmp u_cmp (
    .a   (mem_rdata.val),
    .b   (value_r),
    .res (cmp_res)
  );

  assign idx_dec   = idx_r - CW'(1);
  assign idx_inc   = idx_r + CW'(1);
  assign rd_up     = rd_addr_r + CW'(1);
  assign rd_dn     = rd_addr_r - CW'(1);
  assign pos_inc   = pos_r + CW'(1);
  assign wr_inc    = wr_idx_r + CW'(1);
  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);

  assign scan_hit = pend_r && !cmp_res.lt;
  assign scan_end = (idx_r == count_r);
  assign ins_more = (idx_r > pos_r);
  assign rem_more = (idx_r < count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign out_free = !out_valid_r || out_ready;
  assign keep_hit = pend_r && mem_rdata.mark;

  assign in_ready = (state_r == sise_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sise_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == sise_pkg::MODE_FINISH) ? sise_pkg::ST_COMPACT
                                                         : sise_pkg::ST_SCAN;
        end
      end
      sise_pkg::ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = sise_pkg::ST_DECIDE;
        end
      end
      sise_pkg::ST_DECIDE: begin
        case (mode_r)
          sise_pkg::MODE_INSERT: begin
            state_nxt = (found_r || full) ? sise_pkg::ST_EDGE_LO : sise_pkg::ST_INS_SHIFT;
          end
          sise_pkg::MODE_REMOVE: begin
            state_nxt = found_r ? sise_pkg::ST_REM_SHIFT : sise_pkg::ST_EDGE_LO;
          end
          default: begin
            state_nxt = sise_pkg::ST_EDGE_LO;
          end
        endcase
      end
      sise_pkg::ST_INS_SHIFT: begin
        if (!ins_more && !pend_r) begin
          state_nxt = sise_pkg::ST_EDGE_LO;
        end
      end
      sise_pkg::ST_REM_SHIFT: begin
        if (!rem_more) begin
          state_nxt = sise_pkg::ST_EDGE_LO;
        end
      end
      sise_pkg::ST_COMPACT: begin
        if (!rem_more) begin
          state_nxt = sise_pkg::ST_EDGE_LO;
        end
      end
      sise_pkg::ST_EDGE_LO: begin
        state_nxt = (count_r == '0) ? sise_pkg::ST_DONE : sise_pkg::ST_EDGE_HI;
      end
      sise_pkg::ST_EDGE_HI: begin
        state_nxt = sise_pkg::ST_EDGE_END;
      end
      sise_pkg::ST_EDGE_END: begin
        state_nxt = sise_pkg::ST_DONE;
      end
      sise_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sise_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sise_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mode_nxt         = mode_r;
    value_nxt        = value_r;
    count_nxt        = count_r;
    pos_nxt          = pos_r;
    idx_nxt          = idx_r;
    rd_addr_nxt      = rd_addr_r;
    wr_idx_nxt       = wr_idx_r;
    pend_nxt         = pend_r;
    found_nxt        = found_r;
    status_nxt       = status_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    out_found_nxt    = out_found_r;
    out_status_nxt   = out_status_r;
    out_count_nxt    = out_count_r;
    out_smallest_nxt = out_smallest_r;
    out_largest_nxt  = out_largest_r;
    out_is_empty_nxt = out_is_empty_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    mem_raddr        = '0;

    case (state_r)
      sise_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          value_nxt  = in_value;
          idx_nxt    = '0;
          wr_idx_nxt = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
        end
      end
      sise_pkg::ST_SCAN: begin
        if (scan_hit) begin
          pos_nxt   = rd_addr_r;
          found_nxt = cmp_res.eq;
          pend_nxt  = 1'b0;
        end else if (scan_end) begin
          pos_nxt   = count_r;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = idx_r[AW-1:0];
          rd_addr_nxt = idx_r;
          idx_nxt     = idx_inc;
          pend_nxt    = 1'b1;
        end
      end
      sise_pkg::ST_DECIDE: begin
        case (mode_r)
          sise_pkg::MODE_INSERT: begin
            idx_nxt = count_r;
            if (!found_r && full) begin
              status_nxt = 1'b1;
            end
          end
          sise_pkg::MODE_REMOVE: begin
            idx_nxt = pos_inc;
          end
          sise_pkg::MODE_MARK: begin
            if (found_r) begin
              mem_we         = 1'b1;
              mem_waddr      = pos_r[AW-1:0];
              mem_wdata.mark = 1'b1;
              mem_wdata.val  = value_r;
            end
          end
          sise_pkg::MODE_QUERY: begin
          end
          default: begin
          end
        endcase
      end
      sise_pkg::ST_INS_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_up[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (ins_more) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_dec[AW-1:0];
          rd_addr_nxt = idx_dec;
          idx_nxt     = idx_dec;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we         = 1'b1;
            mem_waddr      = pos_r[AW-1:0];
            mem_wdata.mark = 1'b0;
            mem_wdata.val  = value_r;
            count_nxt      = count_inc;
          end
        end
      end
      sise_pkg::ST_REM_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_dn[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (rem_more) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_r[AW-1:0];
          rd_addr_nxt = idx_r;
          idx_nxt     = idx_inc;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_dec;
        end
      end
      sise_pkg::ST_COMPACT: begin
        if (keep_hit) begin
          mem_we         = 1'b1;
          mem_waddr      = wr_idx_r[AW-1:0];
          mem_wdata.mark = 1'b0;
          mem_wdata.val  = mem_rdata.val;
          wr_idx_nxt     = wr_inc;
        end
        if (rem_more) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_inc;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = keep_hit ? wr_inc : wr_idx_r;
        end
      end
      sise_pkg::ST_EDGE_LO: begin
        if (count_r == '0) begin
          lo_nxt = '0;
          hi_nxt = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
      end
      sise_pkg::ST_EDGE_HI: begin
        lo_nxt    = mem_rdata.val;
        mem_re    = 1'b1;
        mem_raddr = count_dec[AW-1:0];
      end
      sise_pkg::ST_EDGE_END: begin
        hi_nxt = mem_rdata.val;
      end
      sise_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = found_r;
          out_status_nxt   = status_r;
          out_count_nxt    = sise_pkg::COUNT_W'(count_r);
          out_smallest_nxt = lo_r;
          out_largest_nxt  = hi_r;
          out_is_empty_nxt = (count_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sise_pkg::ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r         <= mode_nxt;
    value_r        <= value_nxt;
    pos_r          <= pos_nxt;
    idx_r          <= idx_nxt;
    rd_addr_r      <= rd_addr_nxt;
    wr_idx_r       <= wr_idx_nxt;
    found_r        <= found_nxt;
    status_r       <= status_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    out_found_r    <= out_found_nxt;
    out_status_r   <= out_status_nxt;
    out_count_r    <= out_count_nxt;
    out_smallest_r <= out_smallest_nxt;
    out_largest_r  <= out_largest_nxt;
    out_is_empty_r <= out_is_empty_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_smallest = out_smallest_r;
  assign out_largest  = out_largest_r;
  assign out_is_empty = out_is_empty_r;

endmodule

>>> verif/sorted_integer_set_engine_test.sv
// Self-checking testbench for the sorted integer set engine: directed and random beats against a set predictor.
`timescale 1ns / 100ps

module sorted_integer_set_engine_test;

  localparam int SET_CAPACITY = 64;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [sise_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [sise_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam int RANDOM_ITEMS = 1750;

  typedef logic [sise_pkg::VAL_W-1:0] word_t;

  typedef struct packed {
    logic                         found;
    logic                         status;
    logic [sise_pkg::COUNT_W-1:0] count;
    logic [sise_pkg::VAL_W-1:0]   smallest;
    logic [sise_pkg::VAL_W-1:0]   largest;
    logic                         is_empty;
  } set_result_t;

  typedef struct {
    logic [2:0]                 mode;
    logic [sise_pkg::VAL_W-1:0] value;
    bit                         hold;
    int                         gap;
  } set_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [2:0] in_mode = sise_pkg::MODE_QUERY;
  logic [sise_pkg::VAL_W-1:0] in_value = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_found;
  logic out_status;
  logic [sise_pkg::COUNT_W-1:0] out_count;
  logic [sise_pkg::VAL_W-1:0] out_smallest;
  logic [sise_pkg::VAL_W-1:0] out_largest;
  logic out_is_empty;

  set_op_t op_backlog[$];
  set_result_t predicted_results[$];
  logic [sise_pkg::VAL_W-1:0] value_pool[$];
  logic [sise_pkg::VAL_W-1:0] fill_values[$];

  logic signed [sise_pkg::VAL_W-1:0] set_val [SET_CAPACITY];
  bit set_mark [SET_CAPACITY];
  int set_len = 0;

  int sent_cnt = 0;
  int rcv_cnt = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int sink_cyc = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  set_op_t drive_op;
  set_result_t want;

  always #1 clk = ~clk;

  sorted_integer_set_engine u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_smallest (out_smallest),
    .out_largest  (out_largest),
    .out_is_empty (out_is_empty)
  );

  function automatic set_result_t apply_set_op(logic [2:0] mode,
                                               logic signed [sise_pkg::VAL_W-1:0] v);
    set_result_t r;
    int pos;
    int i;
    int wr;
    bit hit;
    pos = 0;
    while (pos < set_len && set_val[pos] < v) pos++;
    hit = (pos < set_len) && (set_val[pos] == v);
    r.found = hit;
    r.status = 1'b0;
    case (mode)
      sise_pkg::MODE_INSERT: begin
        if (!hit) begin
          if (set_len >= SET_CAPACITY) begin
            r.status = 1'b1;
          end else begin
            for (i = set_len; i > pos; i--) begin
              set_val[i] = set_val[i-1];
              set_mark[i] = set_mark[i-1];
            end
            set_val[pos] = v;
            set_mark[pos] = 1'b0;
            set_len++;
          end
        end
      end
      sise_pkg::MODE_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < set_len; i++) begin
            set_val[i] = set_val[i+1];
            set_mark[i] = set_mark[i+1];
          end
          set_len--;
          set_mark[set_len] = 1'b0;
        end
      end
      sise_pkg::MODE_MARK: begin
        if (hit) set_mark[pos] = 1'b1;
      end
      sise_pkg::MODE_FINISH: begin
        r.found = 1'b0;
        wr = 0;
        for (i = 0; i < set_len; i++) begin
          if (set_mark[i]) begin
            set_val[wr] = set_val[i];
            wr++;
          end
        end
        set_len = wr;
        for (i = 0; i < SET_CAPACITY; i++) set_mark[i] = 1'b0;
      end
      default: begin
      end
    endcase
    r.count = set_len[sise_pkg::COUNT_W-1:0];
    r.is_empty = (set_len == 0);
    r.smallest = (set_len == 0) ? '0 : set_val[0];
    r.largest = (set_len == 0) ? '0 : set_val[set_len-1];
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [sise_pkg::VAL_W-1:0] got,
                             logic [sise_pkg::VAL_W-1:0] exp_val);
    if (got !== exp_val)
      note_mismatch($sformatf("%s on result beat %0d: got %0h, expected %0h",
                              name, rcv_cnt, got, exp_val));
  endtask

  task automatic add_item(logic [2:0] mode, logic [sise_pkg::VAL_W-1:0] value, bit hold);
    set_op_t op;
    int r;
    r = $urandom_range(0, 99);
    op.mode = mode;
    op.value = value;
    op.hold = hold;
    if (src_calm || r < 60) op.gap = 0;
    else if (r < 92) op.gap = $urandom_range(1, 3);
    else op.gap = $urandom_range(10, 30);
    op_backlog.push_back(op);
  endtask

  function automatic logic [sise_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && value_pool.size() != 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (r < 85 && fill_values.size() != 0)
      return fill_values[$urandom_range(0, fill_values.size() - 1)];
    return $urandom;
  endfunction

  task automatic refresh_pool();
    int n;
    int r;
    value_pool.delete();
    n = $urandom_range(12, 40);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        case ($urandom_range(0, 5))
          0: value_pool.push_back(VAL_MIN);
          1: value_pool.push_back(VAL_MAX);
          2: value_pool.push_back(VAL_MIN + 1);
          3: value_pool.push_back(VAL_MAX - 1);
          4: value_pool.push_back('0);
          default: value_pool.push_back('1);
        endcase
      end else if (r < 50) begin
        value_pool.push_back(32'($urandom_range(0, 128)) - 32'd64);
      end else begin
        value_pool.push_back($urandom);
      end
    end
  endtask

  // driver: one beat in flight, gaps drawn per item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(apply_set_op(in_mode, in_value));
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() != 0 &&
                     !(op_backlog[0].hold && rcv_cnt != sent_cnt)) begin
          drive_op = op_backlog.pop_front();
          in_mode <= drive_op.mode;
          in_value <= drive_op.value;
          in_valid <= 1'b1;
          gap_left = drive_op.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      sink_cyc++;
      if (sink_cyc % 1500 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          note_mismatch($sformatf("result beat %0d arrived with nothing expected", rcv_cnt));
        end else begin
          want = predicted_results.pop_front();
          check_field("found", word_t'(out_found), word_t'(want.found));
          check_field("status", word_t'(out_status), word_t'(want.status));
          check_field("count", word_t'(out_count), word_t'(want.count));
          check_field("smallest", out_smallest, want.smallest);
          check_field("largest", out_largest, want.largest);
          check_field("is_empty", word_t'(out_is_empty), word_t'(want.is_empty));
        end
        rcv_cnt <= rcv_cnt + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 99) < 25)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  initial begin : stim
    int n;
    int r;
    int target;
    bit first;
    // directed
    add_item(sise_pkg::MODE_QUERY, VAL_MIN, 1'b0);
    add_item(sise_pkg::MODE_REMOVE, 32'd5, 1'b0);
    add_item(sise_pkg::MODE_FINISH, '0, 1'b0);
    add_item(sise_pkg::MODE_INSERT, VAL_MAX, 1'b0);
    add_item(sise_pkg::MODE_INSERT, VAL_MIN, 1'b0);
    add_item(sise_pkg::MODE_INSERT, '0, 1'b0);
    add_item(sise_pkg::MODE_INSERT, '1, 1'b0);
    add_item(sise_pkg::MODE_INSERT, '0, 1'b0);
    add_item(sise_pkg::MODE_QUERY, '1, 1'b0);
    add_item(sise_pkg::MODE_QUERY, 32'd1, 1'b0);
    add_item(MODE_UNUSED_LO, '0, 1'b0);
    add_item(MODE_UNUSED_HI, VAL_MAX, 1'b0);
    add_item(MODE_UNUSED_LO + 3'd1, 32'd123, 1'b0);
    add_item(sise_pkg::MODE_REMOVE, '1, 1'b0);
    add_item(sise_pkg::MODE_REMOVE, 32'd7, 1'b0);
    add_item(sise_pkg::MODE_MARK, VAL_MIN, 1'b0);
    add_item(sise_pkg::MODE_MARK, VAL_MAX, 1'b0);
    add_item(sise_pkg::MODE_MARK, 32'd3, 1'b0);
    add_item(sise_pkg::MODE_FINISH, 32'h5a5a_5a5a, 1'b0);
    add_item(sise_pkg::MODE_INSERT, 32'd1, 1'b0);
    add_item(sise_pkg::MODE_FINISH, VAL_MAX, 1'b0);
    add_item(sise_pkg::MODE_QUERY, '0, 1'b1);
    add_item(sise_pkg::MODE_INSERT, VAL_MIN + 1, 1'b0);
    add_item(sise_pkg::MODE_REMOVE, VAL_MIN + 1, 1'b0);

    // random sequences
    refresh_pool();
    first = 1'b1;
    target = op_backlog.size() + RANDOM_ITEMS;
    while (op_backlog.size() < target) begin
      if ($urandom_range(0, 9) == 0) src_calm = !src_calm;
      r = $urandom_range(0, 99);
      n = $urandom_range(1, 12);
      if (r < 25) begin
        add_item(sise_pkg::MODE_INSERT, pick_value(), first || $urandom_range(0, 9) == 0);
        repeat (n - 1) add_item(sise_pkg::MODE_INSERT, pick_value(), 1'b0);
      end else if (r < 40) begin
        add_item(sise_pkg::MODE_REMOVE, pick_value(), first || $urandom_range(0, 9) == 0);
        repeat (n - 1) add_item(sise_pkg::MODE_REMOVE, pick_value(), 1'b0);
      end else if (r < 60) begin
        add_item(sise_pkg::MODE_MARK, pick_value(), first || $urandom_range(0, 9) == 0);
        repeat (n - 1) add_item(sise_pkg::MODE_MARK, pick_value(), 1'b0);
        if ($urandom_range(0, 9) != 0) add_item(sise_pkg::MODE_FINISH, $urandom, 1'b0);
      end else if (r < 72) begin
        add_item(sise_pkg::MODE_QUERY, pick_value(), first);
        repeat (n - 1) add_item(sise_pkg::MODE_QUERY, pick_value(), 1'b0);
      end else if (r < 78) begin
        // overfill, then cut back through an intersection
        fill_values.delete();
        n = $urandom_range(66, 72);
        repeat (n) begin
          fill_values.push_back($urandom);
          add_item(sise_pkg::MODE_INSERT, fill_values[$], 1'b0);
        end
        repeat (3) add_item(sise_pkg::MODE_INSERT, fill_values[$urandom_range(0, n - 1)], 1'b0);
        repeat (3) add_item(sise_pkg::MODE_INSERT, pick_value(), 1'b0);
        repeat ($urandom_range(4, 20)) add_item(sise_pkg::MODE_MARK, pick_value(), 1'b0);
        add_item(sise_pkg::MODE_FINISH, $urandom, 1'b0);
      end else if (r < 88) begin
        repeat (n) add_item(3'($urandom_range(0, 7)),
                            ($urandom_range(0, 1) == 0) ? pick_value() : $urandom, 1'b0);
      end else begin
        refresh_pool();
        add_item(sise_pkg::MODE_FINISH, $urandom, $urandom_range(0, 1) == 0);
      end
      first = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (op_backlog.size() != 0 || in_valid || rcv_cnt != sent_cnt) @(negedge clk);
    repeat (160) @(negedge clk);
    if (predicted_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    if (err_cnt == 0) begin
      $display("sorted_integer_set_engine_test: PASS");
    end else begin
      $display("sorted_integer_set_engine_test: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("sorted_integer_set_engine_test: FAIL");
    $finish;
  end

endmodule
